// File: hdl/rpc_pkg.sv
// shared types and constants for the rc pulse to pwm compare block
package rpc_pkg;

	localparam int STAMP_W     = 16;
	localparam int LEVEL_W     = 10;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// x / 100 == (x * 83887) >> 23 for every 16-bit x
	localparam int RECIP_W     = 17;
	localparam int RECIP_SHIFT = 23;
	localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(83887);
	localparam int PROD_W      = STAMP_W + RECIP_W;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_OFFSET = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_JUMP      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_STEP     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TOP_COMPARE   = 3'd5;

	// register reset values
	localparam logic [STAMP_W-1:0] RST_PERIOD_OFFSET = 16'd18900;
	localparam logic [LEVEL_W-1:0] RST_MIN_LEVEL     = 10'd30;
	localparam logic [LEVEL_W-1:0] RST_MAX_LEVEL     = 10'd220;
	localparam logic [LEVEL_W-1:0] RST_MAX_JUMP      = 10'd100;
	localparam logic [STAMP_W-1:0] RST_DUTY_STEP     = 16'd297;
	localparam logic [STAMP_W-1:0] RST_TOP_COMPARE   = 16'd65435;

	typedef struct packed {
		logic               pin_level;
		logic [STAMP_W-1:0] capture_time;
	} event_t;

	typedef struct packed {
		logic [STAMP_W-1:0] compare_value;
		logic               match_enable;
		logic [STAMP_W-1:0] pulse_period;
		logic [LEVEL_W-1:0] throttle_level;
	} result_t;

	typedef struct packed {
		logic [STAMP_W-1:0] period_offset;
		logic [LEVEL_W-1:0] min_level;
		logic [LEVEL_W-1:0] max_level;
		logic [LEVEL_W-1:0] max_jump;
		logic [STAMP_W-1:0] duty_step;
		logic [STAMP_W-1:0] top_compare;
	} cfg_t;

	// item passed from the front part to the back part
	typedef struct packed {
		logic [STAMP_W-1:0] pulse_period;
		logic [LEVEL_W-1:0] raw_level;
	} mid_t;

endpackage

// File: hdl/rc_pulse_to_pwm_compare.sv
// top level: configuration registers, front part, queue and back part
// Each pin edge item yields one result item. A new edge is taken every clock cycle
// while full is low; its result passes the queue, the filter register and the
// result queue to the result ports (empty low) when no older results wait. The
// rate is one item per cycle while the result queue has room, set by the level
// filter in the back part, which compares each raw level with the level left by
// the item before it. Internal queues of four items on each side of the back part
// absorb stalls. Configuration registers are written through cfg_valid/cfg_ready
// (always ready) and should only be changed while no item is in flight.
module rc_pulse_to_pwm_compare (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  rpc_pkg::event_t               pin_event,
	output logic                          empty,
	input  logic                          pop,
	output rpc_pkg::result_t              result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rpc_pkg::STAMP_W-1:0]   cfg_data
);

	rpc_pkg::cfg_t cfg_q;
	rpc_pkg::mid_t wr_item, rd_item;
	logic wr_en, rd_en, mid_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period_offset <= rpc_pkg::RST_PERIOD_OFFSET;
			cfg_q.min_level     <= rpc_pkg::RST_MIN_LEVEL;
			cfg_q.max_level     <= rpc_pkg::RST_MAX_LEVEL;
			cfg_q.max_jump      <= rpc_pkg::RST_MAX_JUMP;
			cfg_q.duty_step     <= rpc_pkg::RST_DUTY_STEP;
			cfg_q.top_compare   <= rpc_pkg::RST_TOP_COMPARE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rpc_pkg::REG_PERIOD_OFFSET: begin
					cfg_q.period_offset <= cfg_data;
				end
				rpc_pkg::REG_MIN_LEVEL: begin
					cfg_q.min_level <= cfg_data[rpc_pkg::LEVEL_W-1:0];
				end
				rpc_pkg::REG_MAX_LEVEL: begin
					cfg_q.max_level <= cfg_data[rpc_pkg::LEVEL_W-1:0];
				end
				rpc_pkg::REG_MAX_JUMP: begin
					cfg_q.max_jump <= cfg_data[rpc_pkg::LEVEL_W-1:0];
				end
				rpc_pkg::REG_DUTY_STEP: begin
					cfg_q.duty_step <= cfg_data;
				end
				rpc_pkg::REG_TOP_COMPARE: begin
					cfg_q.top_compare <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	rpc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.pin_event     (pin_event),
		.period_offset (cfg_q.period_offset),
		.wr_en         (wr_en),
		.wr_item       (wr_item)
	);

	rpc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_item (wr_item),
		.full    (full),
		.rd_en   (rd_en),
		.rd_item (rd_item),
		.empty   (mid_empty)
	);

	rpc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.mid_empty (mid_empty),
		.mid_item  (rd_item),
		.mid_rd    (rd_en),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule

// File: hdl/rpc_front.sv
// front part: edge stamps, pulse period and raw level
module rpc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic            full,
	input  rpc_pkg::event_t pin_event,
	input  logic [rpc_pkg::STAMP_W-1:0] period_offset,
	output logic            wr_en,
	output rpc_pkg::mid_t   wr_item
);

	logic [rpc_pkg::STAMP_W-1:0] rise_q, fall_q;
	logic [rpc_pkg::STAMP_W-1:0] rise_n, fall_n, period, scaled;
	logic [rpc_pkg::PROD_W-1:0]  prod;

	assign wr_en = push && !full;

	always_comb begin
		rise_n = pin_event.pin_level ? pin_event.capture_time : rise_q;
		fall_n = pin_event.pin_level ? fall_q : pin_event.capture_time;
		period = rise_n - fall_n;
		scaled = period - period_offset;
		prod   = rpc_pkg::PROD_W'(scaled) * rpc_pkg::PROD_W'(rpc_pkg::RECIP_100);
		wr_item.pulse_period = period;
		wr_item.raw_level    = prod[rpc_pkg::RECIP_SHIFT +: rpc_pkg::LEVEL_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_q <= '0;
			fall_q <= '0;
		end else if (wr_en) begin
			rise_q <= rise_n;
			fall_q <= fall_n;
		end
	end

endmodule

// File: hdl/rpc_queue.sv
// short queue between the front and back parts
module rpc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  rpc_pkg::mid_t wr_item,
	output logic          full,
	input  logic          rd_en,
	output rpc_pkg::mid_t rd_item,
	output logic          empty
);

	rpc_pkg::mid_t mem_q [rpc_pkg::QUEUE_DEPTH];
	logic [rpc_pkg::QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [rpc_pkg::CNT_W-1:0]    cnt_q;
	logic do_wr, do_rd;

	assign full    = (cnt_q == rpc_pkg::CNT_W'(rpc_pkg::QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/rpc_back.sv
// back part: jump filter, range checks, compare value and result queue
module rpc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  rpc_pkg::cfg_t    cfg,
	input  logic             mid_empty,
	input  rpc_pkg::mid_t    mid_item,
	output logic             mid_rd,
	input  logic             pop,
	output logic             empty,
	output rpc_pkg::result_t result
);

	localparam int LW = rpc_pkg::LEVEL_W;
	localparam int SW = rpc_pkg::STAMP_W;

	// lvl_s1 is also the last level seen by the filter
	logic          valid_s1;
	logic [LW-1:0] lvl_s1;
	logic [SW-1:0] period_s1;

	logic [LW-1:0] diff, pick, lvl_min, lvl_f;
	logic [LW-1:0] span;
	logic [LW+SW-1:0] prod;
	logic          full_drive;
	logic [SW-1:0] cmp;
	rpc_pkg::result_t res;

	rpc_pkg::result_t out_q [rpc_pkg::QUEUE_DEPTH];
	logic [rpc_pkg::QUEUE_AW-1:0] out_wr_q, out_rd_q;
	logic [rpc_pkg::CNT_W-1:0]    out_cnt_q;
	logic [rpc_pkg::CNT_W:0]      pending;
	logic do_pop;

	// take an item only if the result queue has room for it and the one in flight
	assign pending = (rpc_pkg::CNT_W+1)'(out_cnt_q) + (rpc_pkg::CNT_W+1)'(valid_s1);
	assign mid_rd  = !mid_empty && (pending < (rpc_pkg::CNT_W+1)'(rpc_pkg::QUEUE_DEPTH));
	assign empty   = (out_cnt_q == '0);
	assign do_pop  = pop && !empty;
	assign result  = out_q[out_rd_q];

	always_comb begin
		diff    = (mid_item.raw_level >= lvl_s1) ? (mid_item.raw_level - lvl_s1)
		                                         : (lvl_s1 - mid_item.raw_level);
		pick    = (diff > cfg.max_jump) ? lvl_s1 : mid_item.raw_level;
		lvl_min = (pick < cfg.min_level) ? '0 : pick;
		lvl_f   = (lvl_min > cfg.max_level) ? '0 : lvl_min;
	end

	always_comb begin
		// compared without wrap, so max level below two means full drive always
		full_drive = ((LW+1)'(lvl_s1) + (LW+1)'(2)) >= (LW+1)'(cfg.max_level);
		span       = cfg.max_level - lvl_s1;
		prod       = (LW+SW)'(span) * (LW+SW)'(cfg.duty_step);
		if (full_drive) begin
			cmp = cfg.top_compare;
		end else if (lvl_s1 == '0) begin
			cmp = '0;
		end else begin
			cmp = cfg.top_compare - prod[SW-1:0];
		end
		res.compare_value  = cmp;
		res.match_enable   = (cmp != cfg.top_compare);
		res.pulse_period   = period_s1;
		res.throttle_level = lvl_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			lvl_s1   <= '0;
		end else begin
			valid_s1 <= mid_rd;
			if (mid_rd) begin
				lvl_s1 <= lvl_f;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mid_rd) begin
			period_s1 <= mid_item.pulse_period;
		end
		if (valid_s1) begin
			out_q[out_wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q  <= '0;
			out_rd_q  <= '0;
			out_cnt_q <= '0;
		end else begin
			if (valid_s1) begin
				out_wr_q <= out_wr_q + 1'b1;
			end
			if (do_pop) begin
				out_rd_q <= out_rd_q + 1'b1;
			end
			if (valid_s1 && !do_pop) begin
				out_cnt_q <= out_cnt_q + 1'b1;
			end else if (do_pop && !valid_s1) begin
				out_cnt_q <= out_cnt_q - 1'b1;
			end
		end
	end

	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (out_cnt_q < rpc_pkg::CNT_W'(rpc_pkg::QUEUE_DEPTH)))
		else $error("result queue written while full");

	a_out_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_cnt_q <= rpc_pkg::CNT_W'(rpc_pkg::QUEUE_DEPTH))
		else $error("result queue count out of range");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (lvl_s1 == '0) ||
		             ((lvl_s1 >= cfg.min_level) && (lvl_s1 <= cfg.max_level)))
		else $error("filtered level outside configured range");

	a_take_once: assert property (@(posedge clk) disable iff (!arst_n)
		mid_rd |=> valid_s1)
		else $error("taken item lost before the compare stage");

endmodule

// File: bench/pwm_result_checker.sv
// checker for the pulse to compare block: predicts every result and compares what comes out
module pwm_result_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic                          full,
	input  rpc_pkg::event_t               pin_event,
	input  logic                          empty,
	input  logic                          pop,
	input  rpc_pkg::result_t              result,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [rpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rpc_pkg::STAMP_W-1:0]   cfg_data,
	output int                            n_waiting,
	output int                            n_checked,
	output int                            n_failed
);
	import rpc_pkg::*;

	localparam int                 PRINT_CAP = 40;
	localparam logic [STAMP_W-1:0] LEVEL_DIV = 16'd100;

	cfg_t               regs;
	logic [STAMP_W-1:0] rise_at;
	logic [STAMP_W-1:0] fall_at;
	logic [LEVEL_W-1:0] held_level;
	result_t            expected_results[$];
	result_t            want;

	function automatic result_t next_result(input event_t ev);
		logic [STAMP_W-1:0] span;
		logic [STAMP_W-1:0] scaled;
		logic [LEVEL_W-1:0] raw;
		logic [LEVEL_W-1:0] delta;
		logic [LEVEL_W-1:0] lvl;
		logic [31:0]        drop;
		result_t            r;
		if (ev.pin_level) begin
			rise_at = ev.capture_time;
		end else begin
			fall_at = ev.capture_time;
		end
		span   = rise_at - fall_at;
		scaled = span - regs.period_offset;
		raw    = LEVEL_W'(scaled / LEVEL_DIV);
		// a jump larger than the limit keeps the previous level
		delta  = (raw >= held_level) ? raw - held_level : held_level - raw;
		lvl    = (delta > regs.max_jump) ? held_level : raw;
		if (lvl < regs.min_level) lvl = '0;
		if (lvl > regs.max_level) lvl = '0;
		held_level = lvl;
		r.pulse_period   = span;
		r.throttle_level = lvl;
		// full drive test without wrap, so a max level below two always hits it
		if (11'(lvl) + 11'd2 >= 11'(regs.max_level)) begin
			r.compare_value = regs.top_compare;
		end else if (lvl == '0) begin
			r.compare_value = '0;
		end else begin
			drop = 32'(regs.max_level - lvl) * 32'(regs.duty_step);
			r.compare_value = regs.top_compare - drop[STAMP_W-1:0];
		end
		r.match_enable = (r.compare_value != regs.top_compare);
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		if (n_failed < PRINT_CAP) $display("mismatch at %0t: %s", $time, msg);
		n_failed++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = '{RST_PERIOD_OFFSET, RST_MIN_LEVEL, RST_MAX_LEVEL, RST_MAX_JUMP,
				RST_DUTY_STEP, RST_TOP_COMPARE};
			rise_at    = '0;
			fall_at    = '0;
			held_level = '0;
			expected_results.delete();
			n_waiting <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				REG_PERIOD_OFFSET: regs.period_offset = cfg_data;
				REG_MIN_LEVEL:     regs.min_level     = cfg_data[LEVEL_W-1:0];
				REG_MAX_LEVEL:     regs.max_level     = cfg_data[LEVEL_W-1:0];
				REG_MAX_JUMP:      regs.max_jump      = cfg_data[LEVEL_W-1:0];
				REG_DUTY_STEP:     regs.duty_step     = cfg_data;
				REG_TOP_COMPARE:   regs.top_compare   = cfg_data;
				default: ;
				endcase
			end
			if (push && !full) expected_results.push_back(next_result(pin_event));
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result item with nothing waiting, compare %0d",
						result.compare_value));
				end else begin
					want = expected_results.pop_front();
					if (result.compare_value !== want.compare_value)
						report_mismatch($sformatf("item %0d compare_value %0d, expected %0d",
							n_checked, result.compare_value, want.compare_value));
					if (result.match_enable !== want.match_enable)
						report_mismatch($sformatf("item %0d match_enable %0b, expected %0b",
							n_checked, result.match_enable, want.match_enable));
					if (result.pulse_period !== want.pulse_period)
						report_mismatch($sformatf("item %0d pulse_period %0d, expected %0d",
							n_checked, result.pulse_period, want.pulse_period));
					if (result.throttle_level !== want.throttle_level)
						report_mismatch($sformatf("item %0d throttle_level %0d, expected %0d",
							n_checked, result.throttle_level, want.throttle_level));
				end
				n_checked++;
			end
			n_waiting <= expected_results.size();
		end
	end

endmodule

// File: bench/tb.sv
// testbench top: clock, reset, edge stimulus, result draining and the verdict
module tb;
	import rpc_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 12;
	localparam int MAX_RAW      = 655;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam cfg_t RST_SETTINGS = '{RST_PERIOD_OFFSET, RST_MIN_LEVEL, RST_MAX_LEVEL,
		RST_MAX_JUMP, RST_DUTY_STEP, RST_TOP_COMPARE};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	event_t               pin_event;
	logic                 empty;
	logic                 pop;
	result_t              result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [STAMP_W-1:0]   cfg_data;

	int   n_waiting;
	int   n_checked;
	int   n_failed;
	int   cycles = 0;
	int   hold_asks = 0;
	int   burst_left = 0;
	int   edges_sent = 0;
	int   settings_used = 1;
	cfg_t shadow = RST_SETTINGS;
	// jump filter, below minimum, above maximum, full drive near max, largest raw level
	int   directed_levels[11] = '{50, 120, 200, 219, 218, 220, 221, 40, 25, 150, 655};

	rc_pulse_to_pwm_compare u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.pin_event (pin_event),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pwm_result_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.pin_event (pin_event),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.n_waiting (n_waiting),
		.n_checked (n_checked),
		.n_failed  (n_failed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, n_waiting);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic send_edge(input logic lvl, input logic [STAMP_W-1:0] stamp);
		event_t ev;
		int     idle;
		ev.pin_level    = lvl;
		ev.capture_time = stamp;
		if (burst_left == 0) begin
			idle = $urandom_range(0, 6);
			if (idle != 0) begin
				push <= 1'b0;
				repeat (idle) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
		burst_left--;
		push      <= 1'b1;
		pin_event <= ev;
		do @(posedge clk); while (full);
		edges_sent++;
	endtask

	// falling edge then rising edge spaced so the raw level comes out as lvl
	task automatic send_pulse(input int lvl);
		int                 room;
		logic [STAMP_W-1:0] t0;
		room = 65535 - lvl * 100;
		if (room > 99) room = 99;
		t0 = STAMP_W'($urandom);
		send_edge(1'b0, t0);
		send_edge(1'b1, t0 + shadow.period_offset
			+ STAMP_W'(lvl * 100 + int'($urandom_range(0, room))));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STAMP_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic apply_settings(input cfg_t s, input bit junk, input bit spare);
		logic [5:0] pad;
		pad = junk ? 6'($urandom) : 6'd0;
		// high bits above the 10-bit registers are dropped by the block
		write_reg(REG_PERIOD_OFFSET, s.period_offset);
		write_reg(REG_MIN_LEVEL, {pad, s.min_level});
		write_reg(REG_MAX_LEVEL, {pad, s.max_level});
		write_reg(REG_MAX_JUMP, {pad, s.max_jump});
		write_reg(REG_DUTY_STEP, s.duty_step);
		write_reg(REG_TOP_COMPARE, s.top_compare);
		if (spare) begin
			write_reg(REG_SPARE_LO, STAMP_W'($urandom));
			write_reg(REG_SPARE_HI, 16'hFFFF);
		end
		cfg_valid <= 1'b0;
		shadow = s;
		settings_used++;
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (n_waiting != 0);
	endtask

	task automatic run_phase(input int edges_wanted);
		int first;
		int lvl;
		int reach;
		int window;
		int pick;
		first  = edges_sent;
		lvl    = 0;
		reach  = int'(shadow.max_jump) + 3;
		window = int'(shadow.max_level) + 4;
		if (window > MAX_RAW) window = MAX_RAW;
		while (edges_sent - first < edges_wanted) begin
			pick = $urandom_range(0, 9);
			if (pick < 2) begin
				// stray edge: repeated levels and unrelated stamps
				send_edge(1'($urandom), STAMP_W'($urandom));
			end else begin
				if (pick == 2) lvl = $urandom_range(0, MAX_RAW);
				else if (pick == 3) lvl = $urandom_range(0, window);
				else lvl = lvl + int'($urandom_range(0, 2 * reach)) - reach;
				if (lvl < 0) lvl = 0;
				if (lvl > MAX_RAW) lvl = MAX_RAW;
				send_pulse(lvl);
			end
		end
		push <= 1'b0;
	endtask

	initial begin : result_drain
		int mode;
		int mode_left;
		int asks_seen;
		mode      = 0;
		mode_left = 0;
		asks_seen = 0;
		pop <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (asks_seen != hold_asks) begin
				// long hold-off so the block backs up into its input
				asks_seen = hold_asks;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 3);
					mode_left = $urandom_range(16, 96);
				end
				mode_left--;
				case (mode)
				0: pop <= 1'b1;
				1: pop <= 1'($urandom_range(0, 1));
				2: pop <= ($urandom_range(0, 4) == 0);
				default: pop <= (mode_left % 4 == 0);
				endcase
			end
		end
	end

	initial begin : stimulus
		cfg_t s;
		int   p;
		push      <= 1'b0;
		pin_event <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		arst_n    <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stamps at both ends of the counter, then pulses across the level range
		send_edge(1'b1, 16'h0000);
		send_edge(1'b0, 16'hFFFF);
		send_edge(1'b1, 16'hFFFF);
		foreach (directed_levels[i]) send_pulse(directed_levels[i]);
		hold_asks <= hold_asks + 1;
		run_phase(90);

		for (p = 1; p < 8; p++) begin
			wait_drained();
			case (p)
			1: s = '{16'd0, 10'd0, 10'd655, 10'd655, 16'd100, 16'hFFFF};
			2: s = '{16'hFFFF, 10'd655, 10'd2, 10'd0, 16'd0, 16'd0};
			// max level below two: every level is full drive, zero included
			3: s = '{16'd1000, 10'd0, 10'd1, 10'd300, 16'hFFFF, 16'd12345};
			4: s = '{RST_PERIOD_OFFSET, 10'd0, 10'd0, 10'd1023, 16'd297, 16'd65435};
			5: s = '{STAMP_W'($urandom), LEVEL_W'($urandom_range(0, 100)),
				LEVEL_W'($urandom_range(50, 655)), LEVEL_W'($urandom_range(0, 655)),
				STAMP_W'($urandom), STAMP_W'($urandom)};
			6: s = '{STAMP_W'($urandom), LEVEL_W'($urandom_range(0, 655)),
				LEVEL_W'($urandom_range(2, 655)), LEVEL_W'($urandom_range(0, 655)),
				STAMP_W'($urandom), STAMP_W'($urandom)};
			default: s = RST_SETTINGS;
			endcase
			apply_settings(s, p[0], p == 3);
			if (p == 5) hold_asks <= hold_asks + 1;
			run_phase(120);
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d edge items over %0d register settings, %0d results compared",
			edges_sent, settings_used, n_checked);
		$display("incl. counter wrap, jump and range limits, full drive, masked and spare writes");
		if (n_failed == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
